// ===== rtl/tms_pkg.sv =====
// Package for the Turing machine stepper: sizes, mode and status codes,
// request and result types, and the back-end state type.
// No dependencies.
package tms_pkg;

	localparam int STATE_LIMIT  = 16;
	localparam int SYMBOL_LIMIT = 16;
	localparam int TAPE_CELLS   = 256;
	localparam int TT_DEPTH     = STATE_LIMIT * SYMBOL_LIMIT;
	localparam int TT_AW        = $clog2(TT_DEPTH);
	localparam int TAPE_AW      = $clog2(TAPE_CELLS);
	localparam int QDEPTH       = 2;
	localparam int QAW          = $clog2(QDEPTH);

	localparam logic [2:0] MODE_CLEAR  = 3'd0;
	localparam logic [2:0] MODE_LOAD   = 3'd1;
	localparam logic [2:0] MODE_APPEND = 3'd2;
	localparam logic [2:0] MODE_START  = 3'd3;
	localparam logic [2:0] MODE_STEP   = 3'd4;
	localparam logic [2:0] MODE_READ   = 3'd5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_HALTED   = 3'd1;
	localparam logic [2:0] ST_NO_TRANS = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_RANGE    = 3'd4;

	localparam logic [4:0] NSTATES_RESET = 5'd2;
	localparam logic [4:0] NSTATES_MIN   = 5'd2;
	localparam logic [4:0] NSTATES_MAX   = 5'(STATE_LIMIT);

	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_LOAD,
		OP_APPEND,
		OP_START,
		OP_STEP,
		OP_READ,
		OP_NOP
	} tms_op_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [3:0] from_state;
		logic [3:0] read_symbol;
		logic [3:0] next_state;
		logic [3:0] write_symbol;
		logic       move_left;
		logic [7:0] cell_index;
	} tms_cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] machine_state;
		logic [7:0] head_position;
		logic [8:0] tape_length;
		logic [3:0] cell_symbol;
	} tms_result_t;

	// Action stored in the transition table.
	typedef struct packed {
		logic [3:0] next_state;
		logic [3:0] write_symbol;
		logic       move_left;
	} tms_act_t;

	// Classified request as it sits in the queue.
	typedef struct packed {
		tms_op_t          op;
		logic             bad;
		logic [TT_AW-1:0] key;
		tms_act_t         act;
		logic [7:0]       cell_index;
	} tms_entry_t;

	// Head of the queue as seen by the back end.
	typedef struct packed {
		logic       valid;
		tms_entry_t entry;
	} tms_qhead_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RDWAIT,
		BK_SYM,
		BK_LOOK
	} tms_bstate_t;

endpackage

// ===== rtl/tms_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tms_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/tms_front.sv =====
// Front end: takes requests, decodes the mode and range-checks loads.
// Depends on tms_pkg.
module tms_front (
	input  logic            start,
	input  tms_pkg::tms_cmd_t cmd,
	input  logic            full,
	input  logic [4:0]      eff_n,
	output logic            push,
	output tms_pkg::tms_entry_t entry
);
	import tms_pkg::*;

	assign push = start && !full;

	always_comb begin
		entry.bad = ({1'b0, cmd.from_state} >= eff_n) ||
			({1'b0, cmd.next_state} >= eff_n) ||
			({1'b0, cmd.read_symbol} >= 5'(SYMBOL_LIMIT));
		entry.key = TT_AW'({cmd.from_state, cmd.read_symbol});
		entry.act.next_state = cmd.next_state;
		entry.act.write_symbol = cmd.write_symbol;
		entry.act.move_left = cmd.move_left;
		entry.cell_index = cmd.cell_index;
		case (cmd.mode)
			MODE_CLEAR:  entry.op = OP_CLEAR;
			MODE_LOAD:   entry.op = OP_LOAD;
			MODE_APPEND: entry.op = OP_APPEND;
			MODE_START:  entry.op = OP_START;
			MODE_STEP:   entry.op = OP_STEP;
			MODE_READ:   entry.op = OP_READ;
			default:     entry.op = OP_NOP;
		endcase
	end

endmodule

// ===== rtl/tms_queue.sv =====
// Short FIFO of classified requests between the front and back ends.
// Depends on tms_pkg.
module tms_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tms_pkg::tms_entry_t wentry,
	input  logic                pop,
	output logic                full,
	output tms_pkg::tms_qhead_t head
);
	import tms_pkg::*;

	tms_entry_t     slot_q [QDEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [QAW:0]   count_q;
	logic           do_pop;

	assign full = (count_q == (QAW+1)'(QDEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = slot_q[rptr_q];
	assign do_pop = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wentry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QAW'(QDEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == QAW'(QDEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/tms_back.sv =====
// Back end: executes queued requests against the tape and transition RAMs.
// Depends on tms_pkg and tms_ram.
module tms_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [4:0]          eff_n,
	input  tms_pkg::tms_qhead_t head,
	output logic                pop,
	output logic                done,
	output tms_pkg::tms_result_t result
);
	import tms_pkg::*;

	tms_bstate_t        st_q, st_d;
	logic [TAPE_AW-1:0] start_q, start_d;
	logic [8:0]         used_q, used_d;
	logic [9:0]         head_q, head_d;
	logic [3:0]         cur_q, cur_d;
	logic [TT_DEPTH-1:0] valid_q;
	logic [TAPE_AW-1:0] pos_q, pos_d;
	logic [TT_AW-1:0]   key_q, key_d;
	tms_result_t        res_q, res_d;
	logic               done_q;

	logic               tape_we, tape_re;
	logic [TAPE_AW-1:0] tape_waddr, tape_raddr;
	logic [3:0]         tape_wdata, tape_rdata;
	logic               tt_we, tt_re;
	logic [TT_AW-1:0]   tt_waddr, tt_raddr;
	logic [8:0]         tt_rdata;
	tms_act_t           tt_act;
	logic               vclr, vset;
	logic               fin;
	logic [2:0]         sts;
	logic [3:0]         sym;

	logic halted, off_end, tape_full;
	tms_entry_t e;

	assign e = head.entry;
	assign halted = ({1'b0, cur_q} >= (eff_n - 5'd1));
	assign off_end = head_q[9] || (head_q[8:0] >= used_q);
	assign tape_full = (used_q >= 9'(TAPE_CELLS));
	assign tt_act = tms_act_t'(tt_rdata);

	tms_ram #(.WIDTH(4), .DEPTH(TAPE_CELLS)) u_tape (
		.clk(clk), .we(tape_we), .waddr(tape_waddr), .wdata(tape_wdata),
		.re(tape_re), .raddr(tape_raddr), .rdata(tape_rdata)
	);

	tms_ram #(.WIDTH($bits(tms_act_t)), .DEPTH(TT_DEPTH)) u_trans (
		.clk(clk), .we(tt_we), .waddr(tt_waddr), .wdata(e.act),
		.re(tt_re), .raddr(tt_raddr), .rdata(tt_rdata)
	);

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE: begin
				if (head.valid) begin
					if (e.op == OP_READ && ({1'b0, e.cell_index} < used_q)) begin
						st_d = BK_RDWAIT;
					end else if (e.op == OP_STEP && !halted) begin
						if (!off_end) begin
							st_d = BK_SYM;
						end else if (!tape_full) begin
							st_d = BK_LOOK;
						end
					end
				end
			end
			BK_RDWAIT: st_d = BK_IDLE;
			BK_SYM:    st_d = BK_LOOK;
			BK_LOOK:   st_d = BK_IDLE;
			default:   st_d = BK_IDLE;
		endcase
	end

	// Datapath controls and the result.
	always_comb begin
		start_d = start_q;
		used_d = used_q;
		head_d = head_q;
		cur_d = cur_q;
		pos_d = pos_q;
		key_d = key_q;
		tape_we = 1'b0;
		tape_waddr = start_q + used_q[TAPE_AW-1:0];
		tape_wdata = e.act.write_symbol;
		tape_re = 1'b0;
		tape_raddr = start_q + e.cell_index;
		tt_we = 1'b0;
		tt_waddr = e.key;
		tt_re = 1'b0;
		vclr = 1'b0;
		vset = 1'b0;
		fin = 1'b0;
		pop = 1'b0;
		sts = ST_OK;
		sym = 4'd0;
		case (st_q)
			BK_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					case (e.op)
						OP_CLEAR: begin
							vclr = 1'b1;
							start_d = '0;
							used_d = '0;
							head_d = '0;
							cur_d = '0;
							fin = 1'b1;
						end
						OP_LOAD: begin
							if (e.bad) begin
								sts = ST_RANGE;
							end else begin
								tt_we = 1'b1;
								vset = 1'b1;
							end
							fin = 1'b1;
						end
						OP_APPEND: begin
							if (tape_full) begin
								sts = ST_FULL;
							end else begin
								tape_we = 1'b1;
								used_d = used_q + 9'd1;
							end
							fin = 1'b1;
						end
						OP_START: begin
							head_d = '0;
							fin = 1'b1;
						end
						OP_STEP: begin
							if (halted) begin
								sts = ST_HALTED;
								fin = 1'b1;
							end else if (off_end && tape_full) begin
								sts = ST_FULL;
								fin = 1'b1;
							end else if (off_end) begin
								// Grow the tape with a blank at the end the head left.
								used_d = used_q + 9'd1;
								if (head_q[9]) begin
									start_d = start_q - 1'b1;
									head_d = '0;
								end
								pos_d = start_d + head_d[TAPE_AW-1:0];
								tape_we = 1'b1;
								tape_waddr = pos_d;
								tape_wdata = 4'd0;
								key_d = TT_AW'({cur_q, 4'd0});
								tt_re = 1'b1;
							end else begin
								pos_d = start_q + head_q[TAPE_AW-1:0];
								tape_re = 1'b1;
								tape_raddr = pos_d;
							end
						end
						OP_READ: begin
							if ({1'b0, e.cell_index} < used_q) begin
								tape_re = 1'b1;
							end else begin
								fin = 1'b1;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			BK_RDWAIT: begin
				sym = tape_rdata;
				fin = 1'b1;
			end
			BK_SYM: begin
				key_d = TT_AW'({cur_q, tape_rdata});
				tt_re = 1'b1;
			end
			BK_LOOK: begin
				if (valid_q[key_q]) begin
					tape_we = 1'b1;
					tape_waddr = pos_q;
					tape_wdata = tt_act.write_symbol;
					cur_d = tt_act.next_state;
					head_d = tt_act.move_left ? head_q - 10'd1 : head_q + 10'd1;
					sym = tt_act.write_symbol;
				end else begin
					sts = ST_NO_TRANS;
				end
				fin = 1'b1;
			end
			default: ;
		endcase
		// The table is read at the key chosen in this cycle.
		tt_raddr = key_d;
		res_d.status = sts;
		res_d.machine_state = cur_d;
		res_d.head_position = head_d[7:0];
		res_d.tape_length = used_d;
		res_d.cell_symbol = sym;
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		key_q <= key_d;
		if (fin) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			start_q <= '0;
			used_q <= '0;
			head_q <= '0;
			cur_q <= '0;
			valid_q <= '0;
			done_q <= 1'b0;
		end else begin
			st_q <= st_d;
			start_q <= start_d;
			used_q <= used_d;
			head_q <= head_d;
			cur_q <= cur_d;
			done_q <= fin;
			if (vclr) begin
				valid_q <= '0;
			end else if (vset) begin
				valid_q[e.key] <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign result = res_q;

endmodule

// ===== rtl/turing_machine_stepper.sv =====
// Top level of the single-tape Turing machine stepper.
// Depends on tms_pkg, tms_front, tms_queue, tms_back and tms_ram.
//
//  Channel    Signals                 Handshake
//  ---------  ----------------------  ---------------------------------------
//  request    start, busy, cmd        taken on a clock edge with start && !busy
//  result     done, result            valid for one cycle while done is high
//  config     cfg_we, cfg_wdata       state count written when cfg_we is high
//
// A taken request is written into the queue before the back end sees it.
// Clear, load, append, start, the unused modes, a read past the end and a
// refused step finish in the idle state. An in-range read passes through
// BK_RDWAIT, a step that grows the tape through BK_LOOK (transition read),
// and a step on an existing cell through BK_SYM and BK_LOOK: the back end's
// two registered RAM reads, tape cell then transition entry, in turn.
// Reset clears the transition valid bits, the tape bookkeeping, the queue and
// the state count (to 2) at once; no clearing pass is needed.
// busy is high only while the two-entry queue is full. The receiver cannot
// stall, so every result leaves in the cycle after it is produced.
module turing_machine_stepper (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  tms_pkg::tms_cmd_t    cmd,
	output logic                 busy,
	output logic                 done,
	output tms_pkg::tms_result_t result,
	input  logic                 cfg_we,
	input  logic [4:0]           cfg_wdata
);
	import tms_pkg::*;

	logic [4:0] nstates_q;
	logic [4:0] eff_n;
	logic       push;
	logic       full;
	logic       pop;
	tms_entry_t entry;
	tms_qhead_t qhead;

	// The state count register. The user must write it only while the block is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nstates_q <= NSTATES_RESET;
		end else if (cfg_we) begin
			nstates_q <= cfg_wdata;
		end
	end

	// Effective number of states, clamped into the legal range. The last
	// state below that count (eff_n - 1) is the halting state.
	always_comb begin
		if (nstates_q < NSTATES_MIN) begin
			eff_n = NSTATES_MIN;
		end else if (nstates_q > NSTATES_MAX) begin
			eff_n = NSTATES_MAX;
		end else begin
			eff_n = nstates_q;
		end
	end

	// The front end decodes each request and range-checks transition loads
	// as it is taken, so the back end only has to execute.
	tms_front u_front (
		.start(start),
		.cmd(cmd),
		.full(full),
		.eff_n(eff_n),
		.push(push),
		.entry(entry)
	);

	// Two queued requests decouple acceptance from multi-cycle steps.
	tms_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wentry(entry),
		.pop(pop),
		.full(full),
		.head(qhead)
	);

	// The back end owns the tape, the transition table and all machine state.
	tms_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.eff_n(eff_n),
		.head(qhead),
		.pop(pop),
		.done(done),
		.result(result)
	);

	assign busy = full;

endmodule

// ===== rtl/tms_checker.sv =====
// Port-level checker for the Turing machine stepper, bound to the top level.
// Depends on tms_pkg.
module tms_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input tms_pkg::tms_result_t result
);
	import tms_pkg::*;

	logic [2:0] outstanding_q;
	logic       accept;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			case ({accept, done})
				2'b10:   outstanding_q <= outstanding_q + 3'd1;
				2'b01:   outstanding_q <= outstanding_q - 3'd1;
				default: outstanding_q <= outstanding_q;
			endcase
		end
	end

	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> outstanding_q != 3'd0)
		else $error("result without an outstanding request");

	a_bounded_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= 3'd4)
		else $error("more requests in flight than the design can hold");

	a_busy_only_when_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> outstanding_q >= 3'd2)
		else $error("busy while the queue cannot be full");

	a_error_clears_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.cell_symbol == 4'd0)
		else $error("failed request reports a symbol");

endmodule

bind turing_machine_stepper tms_checker u_tms_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.result(result)
);

// ===== tb/turing_machine_stepper_tb.sv =====
// Self-checking testbench for the single-tape Turing machine stepper.
// Depends on tms_pkg and turing_machine_stepper; drives requests, predicts each
// result with its own machine model and compares every result field.
`timescale 1ns / 100ps

module turing_machine_stepper_tb;

	import tms_pkg::*;

	// The two mode codes that the block must treat as no-ops.
	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	// Leave margin when idling after the last result.
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_ITEMS  = 200;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	tms_cmd_t    cmd       = '0;
	logic        busy;
	logic        done;
	tms_result_t result;
	logic        cfg_we    = 1'b0;
	logic [4:0]  cfg_wdata = '0;

	turing_machine_stepper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Our own copy of the machine: rule table, circular tape and registers.
	// The head is kept as a signed int so that it can sit one cell past
	// either end of the tape, exactly as the block allows.
	logic        rule_valid [TT_DEPTH];
	tms_act_t    rule_act   [TT_DEPTH];
	logic [3:0]  tape_cells [TAPE_CELLS];
	int          tape_origin;
	int          cells_used;
	int          head_at;
	int          cur_state;
	logic [4:0]  states_cfg = NSTATES_RESET;

	tms_result_t pending_results [$];
	int          errors        = 0;
	int          requests_sent = 0;
	int          cycle_count   = 0;
	int          status_tally [0:4] = '{default: 0};
	bit          gaps_on       = 1'b1;

	// The programmed state count is clamped to the range the block supports.
	function automatic int live_states();
		int n;
		n = int'(states_cfg);
		if (n < int'(NSTATES_MIN))
			n = int'(NSTATES_MIN);
		if (n > STATE_LIMIT)
			n = STATE_LIMIT;
		return n;
	endfunction

	// Applies one accepted request to the machine copy and returns the result
	// that the block must report for it.
	function automatic tms_result_t predict_result(input tms_cmd_t c);
		tms_result_t r;
		int          n;
		int          key;
		int          pos;
		logic [3:0]  sym;
		bit          room;
		r = '0;
		r.status = ST_OK;
		n = live_states();
		case (c.mode)
			MODE_CLEAR: begin
				for (int i = 0; i < TT_DEPTH; i++)
					rule_valid[i] = 1'b0;
				tape_origin = 0;
				cells_used = 0;
				head_at = 0;
				cur_state = 0;
			end
			MODE_LOAD: begin
				if (int'(c.from_state) >= n || int'(c.next_state) >= n ||
						int'(c.read_symbol) >= SYMBOL_LIMIT) begin
					r.status = ST_RANGE;
				end else begin
					key = int'(c.from_state) * SYMBOL_LIMIT + int'(c.read_symbol);
					rule_valid[key] = 1'b1;
					rule_act[key].next_state = c.next_state;
					rule_act[key].write_symbol = c.write_symbol;
					rule_act[key].move_left = c.move_left;
				end
			end
			MODE_APPEND: begin
				if (cells_used >= TAPE_CELLS) begin
					r.status = ST_FULL;
				end else begin
					tape_cells[(tape_origin + cells_used) % TAPE_CELLS] = c.write_symbol;
					cells_used++;
				end
			end
			MODE_START: begin
				head_at = 0;
			end
			MODE_STEP: begin
				if (cur_state >= n - 1) begin
					r.status = ST_HALTED;
				end else begin
					room = 1'b1;
					// A head past either end first grows the tape with a blank.
					if (head_at < 0 || head_at >= cells_used) begin
						if (cells_used >= TAPE_CELLS) begin
							r.status = ST_FULL;
							room = 1'b0;
						end else if (head_at < 0) begin
							tape_origin = (tape_origin + TAPE_CELLS - 1) % TAPE_CELLS;
							tape_cells[tape_origin] = '0;
							cells_used++;
							head_at = 0;
						end else begin
							tape_cells[(tape_origin + cells_used) % TAPE_CELLS] = '0;
							cells_used++;
						end
					end
					if (room) begin
						pos = (tape_origin + head_at) % TAPE_CELLS;
						sym = tape_cells[pos];
						key = cur_state * SYMBOL_LIMIT + int'(sym);
						// The growth is kept even when no rule matches.
						if (!rule_valid[key]) begin
							r.status = ST_NO_TRANS;
						end else begin
							tape_cells[pos] = rule_act[key].write_symbol;
							r.cell_symbol = rule_act[key].write_symbol;
							cur_state = int'(rule_act[key].next_state);
							head_at += rule_act[key].move_left ? -1 : 1;
						end
					end
				end
			end
			MODE_READ: begin
				if (int'(c.cell_index) < cells_used)
					r.cell_symbol = tape_cells[(tape_origin + int'(c.cell_index)) % TAPE_CELLS];
			end
			default: begin
			end
		endcase
		r.machine_state = cur_state[3:0];
		r.head_position = head_at[7:0];
		r.tape_length = cells_used[8:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [8:0] want_v,
			input logic [8:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
			errors++;
		end
	endtask

	// Results cannot be held off, so each one is sampled at the edge that
	// ends its strobe cycle and matched against the oldest prediction.
	always @(posedge clk) begin : result_check
		tms_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %p", $time, result);
				errors++;
			end else begin
				want = pending_results.pop_front();
				status_tally[want.status]++;
				check_field("status", 9'(want.status), 9'(result.status));
				check_field("machine_state", 9'(want.machine_state), 9'(result.machine_state));
				check_field("head_position", 9'(want.head_position), 9'(result.head_position));
				check_field("tape_length", want.tape_length, result.tape_length);
				check_field("cell_symbol", 9'(want.cell_symbol), 9'(result.cell_symbol));
			end
		end
	end

	// A hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results still pending", $time,
				pending_results.size());
			$display("turing_machine_stepper_tb NOT OK");
			$finish;
		end
	end

	// Gap lengths: mostly none or short, now and then a long one. Some
	// stretches of the run turn gaps off entirely to keep the queue full.
	function automatic int pick_gap();
		int roll;
		if (!gaps_on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic rest(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Sends one request and waits for the edge that takes it. start stays
	// high afterwards, so back-to-back requests need no extra edge.
	task automatic send_request(input tms_cmd_t c);
		rest(pick_gap());
		start <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(predict_result(c));
		requests_sent++;
	endtask

	// Stops sending and waits until every predicted result has come back.
	task automatic settle();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The state count is only changed while the machine is idle.
	task automatic set_nstates(input logic [4:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		states_cfg = value;
	endtask

	// Fields a mode does not use carry random bits.
	function automatic tms_cmd_t noise_cmd(input logic [2:0] m);
		tms_cmd_t c;
		c = 28'($urandom);
		c.mode = m;
		return c;
	endfunction

	task automatic do_plain(input logic [2:0] m);
		send_request(noise_cmd(m));
	endtask

	task automatic do_load(input int from, input int rsym, input int nxt,
			input int wsym, input int left);
		tms_cmd_t c;
		c = noise_cmd(MODE_LOAD);
		c.from_state = 4'(from);
		c.read_symbol = 4'(rsym);
		c.next_state = 4'(nxt);
		c.write_symbol = 4'(wsym);
		c.move_left = 1'(left);
		send_request(c);
	endtask

	task automatic do_append(input int sym);
		tms_cmd_t c;
		c = noise_cmd(MODE_APPEND);
		c.write_symbol = 4'(sym);
		send_request(c);
	endtask

	task automatic do_read(input int idx);
		tms_cmd_t c;
		c = noise_cmd(MODE_READ);
		c.cell_index = 8'(idx);
		send_request(c);
	endtask

	// Straight out of reset: a step on an empty tape grows it with a blank and
	// finds no rule, a read past the end gives zero, and the spare modes and a
	// start leave everything as it was.
	task automatic test_after_reset();
		do_plain(MODE_STEP);
		do_read(0);
		do_read(9);
		do_plain(MODE_SPARE_LO);
		do_plain(MODE_SPARE_HI);
		do_plain(MODE_START);
	endtask

	// Counts below the minimum and above the maximum are clamped. For each,
	// a rule at the last state is legal and, where the field can express it,
	// one state further is refused.
	task automatic test_count_value(input logic [4:0] value);
		int n;
		set_nstates(value);
		n = live_states();
		do_plain(MODE_CLEAR);
		do_load(n - 1, 15, n - 1, 15, 1);
		do_load(n, 0, 0, 1, 0);
		do_load(0, 0, n, 1, 0);
	endtask

	// A second load of the same key wins. Moving left from cell zero prepends
	// a blank, and reads then see the tape from its new left end.
	task automatic test_load_and_reload();
		set_nstates(5'd4);
		do_plain(MODE_CLEAR);
		do_append(2);
		do_append(7);
		do_load(0, 2, 1, 9, 0);
		do_load(0, 2, 2, 4, 1);
		do_plain(MODE_START);
		do_plain(MODE_STEP);
		// Hold the sender until the machine is drained once.
		settle();
		do_plain(MODE_STEP);
		do_read(0);
		do_read(1);
		do_read(2);
		do_read(3);
	endtask

	// The halting state follows the count: shrinking the count below the
	// current state halts the machine, and reaching the last state halts it.
	task automatic test_halting();
		set_nstates(5'd8);
		do_plain(MODE_CLEAR);
		do_load(0, 0, 5, 1, 0);
		do_plain(MODE_STEP);
		set_nstates(5'd4);
		do_plain(MODE_STEP);
		set_nstates(5'd0);
		do_plain(MODE_STEP);
		set_nstates(5'd16);
		do_load(5, 0, 15, 2, 1);
		do_plain(MODE_STEP);
		do_plain(MODE_STEP);
	endtask

	// Fills the tape to its last cell, walks the head off the right end (the
	// head reads back as zero there), then off the left end (reads back as
	// 255). With the tape full, appends and growing steps are refused.
	task automatic test_full_tape();
		set_nstates(5'd3);
		do_plain(MODE_CLEAR);
		repeat (TAPE_CELLS - 1) do_append(1);
		do_plain(MODE_START);
		do_load(0, 1, 0, 3, 0);
		do_load(0, 0, 0, 5, 0);
		repeat (TAPE_CELLS) do_plain(MODE_STEP);
		do_plain(MODE_STEP);
		do_append(6);
		do_read(TAPE_CELLS - 1);
		do_read(0);
		do_read(200);
		do_plain(MODE_START);
		do_load(0, 3, 0, 3, 1);
		do_plain(MODE_STEP);
		do_plain(MODE_STEP);
	endtask

	// Random programs: each phase picks a state count and a mostly small alphabet,
	// loads most of the rule table, seeds a short tape and then mostly steps,
	// with reads, restarts, appends, stray loads and spare modes mixed in.
	// Halting rules are made rare so that runs get long before they stop.
	task automatic test_random_programs(input int budget);
		int         issued;
		int         n;
		int         alpha;
		int         roll;
		int         phase_left;
		int         halted_steps;
		logic [4:0] choice;
		issued = 0;
		while (issued < budget) begin
			case ($urandom_range(0, 7))
				0: choice = 5'd0;
				1: choice = 5'd1;
				2: choice = 5'd16;
				3: choice = 5'($urandom_range(17, 31));
				default: choice = 5'($urandom_range(2, 9));
			endcase
			set_nstates(choice);
			gaps_on = ($urandom_range(0, 3) != 0);
			n = live_states();
			alpha = $urandom_range(2, 5);
			if (n <= 4 && $urandom_range(0, 3) == 0)
				alpha = SYMBOL_LIMIT;
			do_plain(MODE_CLEAR);
			issued++;
			for (int s = 0; s < n - 1; s++) begin
				for (int y = 0; y < alpha; y++) begin
					if ($urandom_range(0, 9) < 8) begin
						do_load(s, y, ($urandom_range(0, 19) == 0) ? n - 1 :
							$urandom_range(0, n - 2), $urandom_range(0, alpha - 1),
							$urandom_range(0, 1));
						issued++;
					end
				end
			end
			repeat ($urandom_range(0, 10)) begin
				do_append($urandom_range(0, alpha - 1));
				issued++;
			end
			do_plain(MODE_START);
			issued++;
			phase_left = $urandom_range(60, 160);
			halted_steps = 0;
			while (phase_left > 0 && issued < budget && halted_steps < 4) begin
				roll = $urandom_range(0, 99);
				if (roll < 68) begin
					do_plain(MODE_STEP);
				end else if (roll < 76) begin
					do_read(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) :
						$urandom_range(0, cells_used));
				end else if (roll < 81) begin
					do_plain(MODE_START);
				end else if (roll < 85) begin
					do_append($urandom_range(0, 15));
				end else if (roll < 90) begin
					do_load($urandom_range(0, 15), $urandom_range(0, 15),
						$urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 1));
				end else if (roll < 93) begin
					do_plain(($urandom_range(0, 1) == 0) ? MODE_SPARE_LO : MODE_SPARE_HI);
					// Ignored by the block, so not counted as work.
					issued--;
					phase_left++;
				end else if (roll < 95) begin
					settle();
					issued--;
					phase_left++;
				end else if (roll < 96) begin
					do_plain(MODE_CLEAR);
				end else begin
					do_plain(MODE_STEP);
				end
				issued++;
				phase_left--;
				if (cur_state >= n - 1)
					halted_steps++;
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		for (int i = 0; i < TT_DEPTH; i++)
			rule_valid[i] = 1'b0;
		for (int i = 0; i < TAPE_CELLS; i++)
			tape_cells[i] = '0;
		tape_origin = 0;
		cells_used = 0;
		head_at = 0;
		cur_state = 0;

		// Reset is released on a rising edge.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_count_value(5'd1);
		test_count_value(5'd17);
		test_count_value(5'd31);
		test_load_and_reload();
		test_halting();
		test_full_tape();
		test_random_programs(RANDOM_ITEMS);

		settle();
		$display("Sent %0d requests of every mode under state counts 0 to 31.",
			requests_sent);
		$display("Status mix: ok %0d, halted %0d, no rule %0d, tape full %0d, out of range %0d.",
			status_tally[0], status_tally[1], status_tally[2], status_tally[3], status_tally[4]);
		if (errors == 0) begin
			$display("turing_machine_stepper_tb OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("turing_machine_stepper_tb NOT OK");
		end
		$finish;
	end

endmodule
